### rtl/pvam_pkg.sv
// ----------------------------------------------------------------------------
// pvam_pkg
// Types and constants shared by the video-memory address map.
// ----------------------------------------------------------------------------
package pvam_pkg;

    localparam int ADDR_W     = 16;
    localparam int VADDR_W    = 14;
    localparam int DATA_W     = 8;
    localparam int EXT_ADDR_W = 13;
    localparam int PAL_AW     = 5;
    localparam int PAL_DEPTH  = 32;

    localparam logic       KIND_WRITE   = 1'b0;
    localparam logic       KIND_READ    = 1'b1;
    localparam logic       MIRROR_VERT  = 1'b0;
    localparam logic       MIRROR_HORIZ = 1'b1;
    localparam logic [5:0] PAL_PAGE     = 6'h3F;

    typedef struct packed {
        logic                kind;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
    } t_access_in;

    typedef struct packed {
        logic [DATA_W-1:0]     read_data;
        logic                  external_access;
        logic [EXT_ADDR_W-1:0] external_address;
    } t_access_out;

endpackage

### rtl/pvam_nt_ram.sv
// ----------------------------------------------------------------------------
// pvam_nt_ram
// Single-port name-table RAM, read-first, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module pvam_nt_ram
    import pvam_pkg::*;
#(
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata,
    output logic                     o_clearing
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic              r_clr_act;
    logic [AW-1:0]     r_clr_idx;
    logic              n_clr_act;
    logic [AW-1:0]     n_clr_idx;

    always_comb begin
        n_clr_act = r_clr_act;
        n_clr_idx = r_clr_idx;
        if (r_clr_act) begin
            n_clr_idx = r_clr_idx + AW'(1);
            if (r_clr_idx == LAST) begin
                n_clr_act = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_act <= 1'b1;
            r_clr_idx <= '0;
        end else begin
            r_clr_act <= n_clr_act;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_act) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_en) begin
            r_rdata <= r_mem[i_addr];
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clr_act;

endmodule

### rtl/ppu_vram_address_map_top.sv
// ----------------------------------------------------------------------------
// ppu_vram_address_map_top
// Video-memory address map: name-table mirroring, palette aliasing,
// pattern-region pass-through to the cartridge.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+--------------------------------
//  access   | i_item                         | start & !busy
//  result   | o_result                       | o_strobe, one cycle, no stall
//  config   | i_cfg_wdata (mirror_mode)      | i_cfg_we
//
// One item per cycle while not busy; the result strobes after the store read
// and then the result register.
// After reset all 2*TABLE_BYTES (2048) name-table entries are swept to zero,
// with busy high; busy is also high while reset is held.
// Read-first store access at acceptance keeps back-to-back items coherent.
// ----------------------------------------------------------------------------
module ppu_vram_address_map_top
    import pvam_pkg::*;
#(
    parameter int TABLE_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_access_in  i_item,
    output logic        o_strobe,
    output t_access_out o_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    localparam int NT_DEPTH = 2 * TABLE_BYTES;
    localparam int NT_AW    = $clog2(NT_DEPTH);
    localparam int OFS_W    = $clog2(TABLE_BYTES);

    logic               r_mirror;
    logic               accept;
    logic               clearing;
    logic [VADDR_W-1:0] vaddr;
    logic               is_ext;
    logic               is_pal;
    logic               is_wr;
    logic               nt_phys;
    logic [NT_AW-1:0]   nt_idx;
    logic [PAL_AW-1:0]  pal_idx;
    logic [DATA_W-1:0]  nt_rdata;

    logic [DATA_W-1:0]  r_pal [PAL_DEPTH];
    logic [DATA_W-1:0]  r_pal_rd;
    logic               r_s1_vld;
    logic               r_s1_ext;
    logic               r_s1_pal;
    logic [EXT_ADDR_W-1:0] r_s1_ext_addr;
    logic               r_res_vld;
    t_access_out        r_res;
    t_access_out        n_res;

    assign busy   = clearing | ~i_rst_n;
    assign accept = start & ~busy;

    assign vaddr  = i_item.address[VADDR_W-1:0];
    assign is_ext = ~vaddr[VADDR_W-1];
    assign is_pal = (vaddr[VADDR_W-1:8] == PAL_PAGE);
    assign is_wr  = (i_item.kind == KIND_WRITE);

    assign nt_phys = (r_mirror == MIRROR_HORIZ) ? vaddr[OFS_W+1] : vaddr[OFS_W];
    assign nt_idx  = {nt_phys, vaddr[OFS_W-1:0]};

    always_comb begin
        pal_idx = vaddr[PAL_AW-1:0];
        if (pal_idx[4] && pal_idx[1:0] == 2'b00) begin
            pal_idx[4] = 1'b0;
        end
    end

    pvam_nt_ram #(
        .DEPTH (NT_DEPTH)
    ) u_nt_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (accept & ~is_ext & ~is_pal),
        .i_we       (is_wr),
        .i_addr     (nt_idx),
        .i_wdata    (i_item.write_data),
        .o_rdata    (nt_rdata),
        .o_clearing (clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror <= MIRROR_VERT;
        end else if (i_cfg_we) begin
            r_mirror <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAL_DEPTH; i++) begin
                r_pal[i] <= '0;
            end
        end else if (accept && is_pal) begin
            r_pal_rd <= r_pal[pal_idx];
            if (is_wr) begin
                r_pal[pal_idx] <= i_item.write_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_s1_vld  <= accept;
            r_res_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ext      <= is_ext;
            r_s1_pal      <= is_pal;
            r_s1_ext_addr <= is_ext ? vaddr[EXT_ADDR_W-1:0] : '0;
        end
        r_res <= n_res;
    end

    always_comb begin
        n_res.external_access  = r_s1_ext;
        n_res.external_address = r_s1_ext_addr;
        if (r_s1_ext) begin
            n_res.read_data = '0;
        end else if (r_s1_pal) begin
            n_res.read_data = r_pal_rd;
        end else begin
            n_res.read_data = nt_rdata;
        end
    end

    assign o_strobe = r_res_vld;
    assign o_result = r_res;

endmodule

### rtl/pvam_chk.sv
// ----------------------------------------------------------------------------
// pvam_chk
// Port-level checks for the video-memory address map, bound to the top.
// ----------------------------------------------------------------------------
module pvam_chk
    import pvam_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input t_access_in  i_item,
    input logic        o_strobe,
    input t_access_out o_result
);

    logic acc;
    assign acc = start & ~busy;

    a_strobe_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##2 o_strobe)
        else $error("accepted item produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(acc, 2))
        else $error("result without accepted item");

    a_ext_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##2 (o_result.external_access == ~$past(i_item.address[13], 2)))
        else $error("external flag does not match item address");

    a_ext_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.external_access ? (o_result.read_data == '0)
                                               : (o_result.external_address == '0)))
        else $error("unused result field not zero");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

endmodule

bind ppu_vram_address_map_top pvam_chk u_pvam_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
